### rtl/tgp_pkg.sv
package tgp_pkg;

  // value format and datapath widths
  localparam int VALUE_BITS    = 32;
  localparam int LANES         = 8;
  localparam int AXES          = 3;
  localparam int RATIO_BITS    = 2;
  localparam int SHIFT_BITS    = 4;
  localparam int AXIS_W_BITS   = 5;   // one axis weight in quarters, -6 .. 14
  localparam int PAIR_W_BITS   = 2 * AXIS_W_BITS;
  localparam int WEIGHT_BITS   = 13;  // product of three axis weights, |w| <= 2744
  localparam int PROD_BITS     = VALUE_BITS + WEIGHT_BITS;
  localparam int PAIR_BITS     = PROD_BITS + 1;
  localparam int SUM_BITS      = PROD_BITS + 3;
  localparam int RND_SHIFT     = 9;   // divide by 8 and by the 1/64 weight scale
  localparam int RES_BITS      = SUM_BITS - RND_SHIFT;
  localparam int CMB_BITS      = RES_BITS + 1;
  localparam int PIPE_STAGES   = 6;
  localparam int SB_STAGES     = PIPE_STAGES - 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SHIFT_BITS;

  localparam logic [RATIO_BITS-1:0] RATIO_FLAT  = RATIO_BITS'(1);
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(2);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_ASSIGN = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_SUB    = 2'd2,
    FUNC_KEEP   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RATIO_X = 3'd0,
    CFG_RATIO_Y = 3'd1,
    CFG_RATIO_Z = 3'd2,
    CFG_SHIFT_X = 3'd3,
    CFG_SHIFT_Y = 3'd4,
    CFG_SHIFT_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    func_t        func;
    logic [2:0]   parity;
    value_t       old_fine;
    value_t       c_000;
    value_t       c_100;
    value_t       c_010;
    value_t       c_110;
    value_t       c_001;
    value_t       c_101;
    value_t       c_011;
    value_t       c_111;
  } in_item_t;

  typedef struct packed {
    value_t fine_value;
    logic   saturated;
  } out_item_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

  typedef struct packed {
    logic s3_en;
    logic s4_en;
    logic s5_en;
    logic s6_en;
  } merge_ctl_t;

endpackage

### rtl/trilinear_grid_prolongation.sv
// the result is offered on out_valid from the output register at the end of the pipeline
// throughput: one cell per cycle, set by the eight multiplier lanes and the adder tree
// which all take a new item every cycle; a stalled output holds only the stages behind it
// reset (rst_n low at a clock edge): pipeline emptied, ratios back to 2, shifts back to 0
module trilinear_grid_prolongation import tgp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  // configuration registers
  logic [AXES-1:0][RATIO_BITS-1:0] ratio_r;
  logic [AXES-1:0][SHIFT_BITS-1:0] shift_r;
  logic [AXES-1:0]                 flat;

  // pipeline occupancy, one valid per stage; the last stage is the output register
  logic [PIPE_STAGES-1:0] valid_r;
  logic [PIPE_STAGES-1:0] valid_nxt;
  logic [PIPE_STAGES-1:0] rdy;
  logic [PIPE_STAGES-1:0] en;

  // func and old value ride alongside the lanes until the final combine
  func_t  sb_func_r [SB_STAGES];
  value_t sb_old_r  [SB_STAGES];

  value_t [LANES-1:0]               coarse;
  logic [LANES-1:0][PROD_BITS-1:0]  prod;
  lane_ctl_t                        lane_ctl;
  merge_ctl_t                       merge_ctl;
  value_t                           fine_value;
  logic                             saturated;

  logic in_fire;
  logic out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= {AXES{RATIO_RESET}};
      shift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATIO_X: ratio_r[0] <= cfg_wdata[RATIO_BITS-1:0];
        CFG_RATIO_Y: ratio_r[1] <= cfg_wdata[RATIO_BITS-1:0];
        CFG_RATIO_Z: ratio_r[2] <= cfg_wdata[RATIO_BITS-1:0];
        CFG_SHIFT_X: shift_r[0] <= cfg_wdata[SHIFT_BITS-1:0];
        CFG_SHIFT_Y: shift_r[1] <= cfg_wdata[SHIFT_BITS-1:0];
        CFG_SHIFT_Z: shift_r[2] <= cfg_wdata[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // an unrefined axis reads its neighbour from the centre side
  always_comb begin
    for (int ax = 0; ax < AXES; ax++) begin
      flat[ax] = (ratio_r[ax] == RATIO_FLAT);
    end
  end

  // a stage takes a new item when it is empty or its content moves on
  always_comb begin
    rdy[PIPE_STAGES-1] = !valid_r[PIPE_STAGES-1] || out_ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    en[0]        = rdy[0] && in_valid;
    for (int k = 1; k < PIPE_STAGES; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
      en[k]        = rdy[k] && valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sb_func_r[0] <= in_data.func;
      sb_old_r[0]  <= in_data.old_fine;
    end
    for (int k = 1; k < SB_STAGES; k++) begin
      if (en[k]) begin
        sb_func_r[k] <= sb_func_r[k-1];
        sb_old_r[k]  <= sb_old_r[k-1];
      end
    end
  end

  assign in_ready = rdy[0];
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // coarse neighbours indexed by x | y << 1 | z << 2
  assign coarse[0] = in_data.c_000;
  assign coarse[1] = in_data.c_100;
  assign coarse[2] = in_data.c_010;
  assign coarse[3] = in_data.c_110;
  assign coarse[4] = in_data.c_001;
  assign coarse[5] = in_data.c_101;
  assign coarse[6] = in_data.c_011;
  assign coarse[7] = in_data.c_111;

  assign lane_ctl.s1_en  = en[0];
  assign lane_ctl.s2_en  = en[1];
  assign merge_ctl.s3_en = en[2];
  assign merge_ctl.s4_en = en[3];
  assign merge_ctl.s5_en = en[4];
  assign merge_ctl.s6_en = en[5];

  // one lane per corner of the coarse cube: weight then multiply
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tgp_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .lane_idx (AXES'(i)),
      .flat     (flat),
      .parity   (in_data.parity),
      .shifts   (shift_r),
      .coarse   (coarse),
      .prod     (prod[i])
    );
  end

  // adder tree, rounding, combine with the old value and saturation
  tgp_merge u_merge (
    .clk        (clk),
    .ctl        (merge_ctl),
    .prod       (prod),
    .func       (sb_func_r[SB_STAGES-1]),
    .old_fine   (sb_old_r[SB_STAGES-1]),
    .fine_value (fine_value),
    .saturated  (saturated)
  );

  assign out_valid           = valid_r[PIPE_STAGES-1];
  assign out_data.fine_value = fine_value;
  assign out_data.saturated  = saturated;

  // occupancy grows by one on an input transfer alone
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !out_fire |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("pipeline occupancy did not grow on input transfer");

  // occupancy shrinks by one on an output transfer alone
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && out_fire |=> $countones(valid_r) == $past($countones(valid_r)) - 1)
    else $error("pipeline occupancy did not shrink on output transfer");

  // an empty first stage always takes a transfer
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0] |-> in_ready)
    else $error("input stalled with an empty first stage");

  // a clipped result sits on one of the range limits
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.fine_value == VALUE_MAX || out_data.fine_value == VALUE_MIN)
    else $error("saturated result not at a range limit");

endmodule

### rtl/tgp_lane.sv
module tgp_lane import tgp_pkg::*; (
  input  logic                              clk,
  input  lane_ctl_t                         ctl,
  input  logic [AXES-1:0]                   lane_idx,
  input  logic [AXES-1:0]                   flat,
  input  logic [AXES-1:0]                   parity,
  input  logic [AXES-1:0][SHIFT_BITS-1:0]   shifts,
  input  value_t [LANES-1:0]                coarse,
  output logic [PROD_BITS-1:0]              prod
);

  logic signed [AXIS_W_BITS-1:0] axis_w [AXES];
  logic signed [PAIR_W_BITS-1:0] w_xy;
  logic signed [WEIGHT_BITS-1:0] w_lane;
  logic [AXES-1:0]               sel;

  logic signed [WEIGHT_BITS-1:0] w_r;
  value_t                        v_r;
  logic signed [PROD_BITS-1:0]   prod_r;

  // near weight 6 + o*q, far weight 2 - o*q, in quarters
  always_comb begin
    logic signed [AXIS_W_BITS:0] q_ext;
    logic signed [AXIS_W_BITS:0] oq;
    logic signed [AXIS_W_BITS:0] wa;
    for (int ax = 0; ax < AXES; ax++) begin
      q_ext = (AXIS_W_BITS+1)'($signed(shifts[ax]));
      oq    = parity[ax] ? q_ext : -q_ext;
      wa    = lane_idx[ax] ? ((AXIS_W_BITS+1)'(2) - oq) : ((AXIS_W_BITS+1)'(6) + oq);
      axis_w[ax] = wa[AXIS_W_BITS-1:0];
      sel[ax]    = lane_idx[ax] && !flat[ax];
    end
  end

  assign w_xy   = PAIR_W_BITS'(axis_w[0]) * PAIR_W_BITS'(axis_w[1]);
  assign w_lane = WEIGHT_BITS'(WEIGHT_BITS'(w_xy) * WEIGHT_BITS'(axis_w[2]));

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      w_r <= w_lane;
      v_r <= coarse[sel];
    end
    if (ctl.s2_en) begin
      prod_r <= PROD_BITS'(v_r) * PROD_BITS'(w_r);
    end
  end

  assign prod = prod_r;

endmodule

### rtl/tgp_merge.sv
module tgp_merge import tgp_pkg::*; (
  input  logic                                clk,
  input  merge_ctl_t                          ctl,
  input  logic [LANES-1:0][PROD_BITS-1:0]     prod,
  input  func_t                               func,
  input  value_t                              old_fine,
  output value_t                              fine_value,
  output logic                                saturated
);

  localparam logic signed [SUM_BITS-1:0] HALF_POS = SUM_BITS'(1 << (RND_SHIFT - 1));
  localparam logic signed [SUM_BITS-1:0] HALF_NEG = SUM_BITS'((1 << (RND_SHIFT - 1)) - 1);

  logic signed [PAIR_BITS-1:0] pair_r [LANES/2];
  logic signed [SUM_BITS-1:0]  sum_r;
  logic signed [SUM_BITS-1:0]  rnd;
  logic signed [RES_BITS-1:0]  res_r;
  logic signed [CMB_BITS-1:0]  cmb;
  logic                        fits;
  value_t                      fine_nxt;
  value_t                      fine_r;
  logic                        sat_r;

  // half away from zero: floor((a + 256) / 512) above zero, floor((a + 255) / 512) below
  assign rnd = sum_r + (sum_r[SUM_BITS-1] ? HALF_NEG : HALF_POS);

  always_comb begin
    case (func)
      FUNC_ASSIGN: cmb = CMB_BITS'(res_r);
      FUNC_ADD:    cmb = CMB_BITS'(old_fine) + CMB_BITS'(res_r);
      FUNC_SUB:    cmb = CMB_BITS'(old_fine) - CMB_BITS'(res_r);
      default:     cmb = CMB_BITS'(old_fine);
    endcase
    fits = (&cmb[CMB_BITS-1:VALUE_BITS-1]) || !(|cmb[CMB_BITS-1:VALUE_BITS-1]);
    if (fits) begin
      fine_nxt = cmb[VALUE_BITS-1:0];
    end else if (cmb[CMB_BITS-1]) begin
      fine_nxt = VALUE_MIN;
    end else begin
      fine_nxt = VALUE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      for (int j = 0; j < LANES/2; j++) begin
        pair_r[j] <= PAIR_BITS'($signed(prod[2*j])) + PAIR_BITS'($signed(prod[2*j+1]));
      end
    end
    if (ctl.s4_en) begin
      sum_r <= (SUM_BITS'(pair_r[0]) + SUM_BITS'(pair_r[1]))
             + (SUM_BITS'(pair_r[2]) + SUM_BITS'(pair_r[3]));
    end
    if (ctl.s5_en) begin
      res_r <= rnd[SUM_BITS-1:RND_SHIFT];
    end
    if (ctl.s6_en) begin
      fine_r <= fine_nxt;
      sat_r  <= !fits;
    end
  end

  assign fine_value = fine_r;
  assign saturated  = sat_r;

endmodule
